// ===== sv/adsw_pkg.sv =====
// Shared types and constants of the 1D advection-diffusion sweep block.
// Depends on nothing; every other file imports it.
package adsw_pkg;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 32;

    localparam logic [1:0] FUNC_WRITE = 2'd0;
    localparam logic [1:0] FUNC_RUN   = 2'd1;
    localparam logic [1:0] FUNC_READ  = 2'd2;

    localparam logic [2:0] STATUS_ACCESS   = 3'd0;
    localparam logic [2:0] STATUS_CONV     = 3'd1;
    localparam logic [2:0] STATUS_UNSTABLE = 3'd2;
    localparam logic [2:0] STATUS_LIMIT    = 3'd3;
    localparam logic [2:0] STATUS_BAD      = 3'd4;

    localparam logic [2:0] CFG_DIFFUSION = 3'd0;
    localparam logic [2:0] CFG_ADVECTION = 3'd1;
    localparam logic [2:0] CFG_TOLERANCE = 3'd2;
    localparam logic [2:0] CFG_COUNT     = 3'd3;
    localparam logic [2:0] CFG_PIN_A_IDX = 3'd4;
    localparam logic [2:0] CFG_PIN_A_VAL = 3'd5;
    localparam logic [2:0] CFG_PIN_B_IDX = 3'd6;
    localparam logic [2:0] CFG_PIN_B_VAL = 3'd7;

    localparam logic [15:0]        RST_DIFFUSION = 16'd9830;
    localparam logic signed [16:0] RST_ADVECTION = 17'sd9830;
    localparam logic [30:0]        RST_TOLERANCE = 31'd17;
    localparam logic [7:0]         RST_COUNT     = 8'd101;
    localparam logic [6:0]         RST_PIN_A_IDX = 7'd20;
    localparam logic signed [31:0] RST_PIN_A_VAL = 32'sd16777216;
    localparam logic [6:0]         RST_PIN_B_IDX = 7'd30;
    localparam logic signed [31:0] RST_PIN_B_VAL = 32'sd33554432;

    // Largest stable diffusion coefficient: 0.5 in Q0.16
    localparam logic [15:0] DIFFUSION_LIMIT = 16'd32768;

    typedef struct packed {
        logic [1:0]         func;
        logic [6:0]         point_index;
        logic signed [31:0] point_value;
    } adsw_in_t;

    typedef struct packed {
        logic signed [31:0] read_value;
        logic [2:0]         status;
        logic [15:0]        sweep_count;
        logic [30:0]        max_change;
    } adsw_out_t;

    typedef enum logic [1:0] {RD_ITEM, RD_ZERO, RD_ONE, RD_NEXT} rd_sel_t;
    typedef enum logic [1:0] {REP_NONE, REP_ZERO, REP_READ, REP_RUN} rep_t;
    typedef enum logic [2:0] {
        WR_NONE, WR_CLEAR, WR_ITEM, WR_PIN_A, WR_PIN_B, WR_POINT
    } wr_sel_t;

    typedef struct packed {
        wr_sel_t wr_sel;
        logic    rd_en;
        rd_sel_t rd_sel;
        logic    load_left;
        logic    load_centre;
        logic    calc_lap;
        logic    calc_mul;
        logic    sweep_start;
        logic    run_start;
        logic    sweep_end;
        rep_t    reply;
    } adsw_cmd_t;

    typedef struct packed {
        logic clear_done;
        logic idx_ok;
        logic unstable;
        logic last_point;
        logic converged;
        logic at_limit;
    } adsw_stat_t;

endpackage

// ===== sv/adsw_datapath.sv =====
// Datapath of the sweep block: configuration registers, grid memory and stencil unit.
// Depends on adsw_pkg; driven by adsw_ctrl through adsw_cmd_t.
module adsw_datapath
    import adsw_pkg::*;
#(
    parameter int GRID_DEPTH = 128,
    parameter int MAX_SWEEPS = 65535,
    parameter int VALUE_BITS = 32
)(
    input  logic                   clk,
    input  logic                   rst_n,
    input  adsw_in_t               item,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  adsw_cmd_t              cmd,
    output adsw_stat_t             stat,
    output logic signed [31:0]     out_value,
    output logic [15:0]            out_sweeps,
    output logic [30:0]            out_change
);

    localparam int W  = VALUE_BITS;
    localparam int AW = (GRID_DEPTH > 1) ? $clog2(GRID_DEPTH) : 1;
    localparam int CW = (AW + 1 > 8) ? AW + 1 : 8;
    localparam int XW = (W > 32) ? W : 32;
    localparam int SW = W + 4;
    localparam int PW = W + 19;
    localparam int TW = (W + 1 > 31) ? W + 1 : 31;

    localparam logic signed [XW-1:0] VMAX_X = {{(XW-W+1){1'b0}}, {(W-1){1'b1}}};
    localparam logic signed [XW-1:0] VMIN_X = ~VMAX_X;
    localparam logic signed [XW-1:0] RMAX_X = {{(XW-31){1'b0}}, {31{1'b1}}};
    localparam logic signed [XW-1:0] RMIN_X = ~RMAX_X;
    localparam logic signed [SW-1:0] VMAX_S = {5'b00000, {(W-1){1'b1}}};
    localparam logic signed [SW-1:0] VMIN_S = ~VMAX_S;
    localparam logic signed [PW-1:0] RND    = PW'(32768);
    localparam logic [TW-1:0]        CMAX_T = TW'(31'h7FFF_FFFF);

    function automatic logic signed [W-1:0] sat_in(input logic signed [31:0] v);
        logic signed [XW-1:0] x;
        x = XW'(v);
        if (x > VMAX_X) x = VMAX_X;
        if (x < VMIN_X) x = VMIN_X;
        return x[W-1:0];
    endfunction

    function automatic logic signed [31:0] sat_out(input logic signed [W-1:0] v);
        logic signed [XW-1:0] x;
        x = XW'(v);
        if (x > RMAX_X) x = RMAX_X;
        if (x < RMIN_X) x = RMIN_X;
        return x[31:0];
    endfunction

    // Configuration
    logic [15:0]          diff_reg;
    logic signed [16:0]   adv_reg;
    logic [30:0]          tol_reg;
    logic [7:0]           count_reg;
    logic [6:0]           pin_a_idx_reg, pin_b_idx_reg;
    logic signed [W-1:0]  pin_a_val_reg, pin_b_val_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            diff_reg      <= RST_DIFFUSION;
            adv_reg       <= RST_ADVECTION;
            tol_reg       <= RST_TOLERANCE;
            count_reg     <= RST_COUNT;
            pin_a_idx_reg <= RST_PIN_A_IDX;
            pin_a_val_reg <= sat_in(RST_PIN_A_VAL);
            pin_b_idx_reg <= RST_PIN_B_IDX;
            pin_b_val_reg <= sat_in(RST_PIN_B_VAL);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_DIFFUSION: diff_reg      <= cfg_data[15:0];
                CFG_ADVECTION: adv_reg       <= cfg_data[16:0];
                CFG_TOLERANCE: tol_reg       <= cfg_data[30:0];
                CFG_COUNT:     count_reg     <= cfg_data[7:0];
                CFG_PIN_A_IDX: pin_a_idx_reg <= cfg_data[6:0];
                CFG_PIN_A_VAL: pin_a_val_reg <= sat_in(cfg_data);
                CFG_PIN_B_IDX: pin_b_idx_reg <= cfg_data[6:0];
                CFG_PIN_B_VAL: pin_b_val_reg <= sat_in(cfg_data);
                default: ;
            endcase
        end
    end

    // Active point count, clamped to 3..GRID_DEPTH
    logic [CW-1:0] n;
    always_comb
    begin
        n = CW'(count_reg);
        if (n < CW'(3)) n = CW'(3);
        if (n > CW'(GRID_DEPTH)) n = CW'(GRID_DEPTH);
    end

    logic a_ok, b_ok;
    assign a_ok = CW'(pin_a_idx_reg) < n;
    assign b_ok = CW'(pin_b_idx_reg) < n;

    // Control registers of the sweep
    logic [AW-1:0] clr_reg, pt_reg;
    logic [W:0]    worst_reg;
    logic [30:0]   largest_reg;
    logic [15:0]   sweeps_reg;

    // Grid memory
    logic signed [W-1:0] mem [GRID_DEPTH];
    logic signed [W-1:0] rdata_reg;
    logic [AW-1:0]       raddr, waddr;
    logic signed [W-1:0] wdata;
    logic                we;
    logic signed [W-1:0] nv;

    always_comb
    begin
        case (cmd.rd_sel)
            RD_ITEM: raddr = AW'(item.point_index);
            RD_ZERO: raddr = '0;
            RD_ONE:  raddr = AW'(1);
            RD_NEXT: raddr = pt_reg + AW'(1);
            default: raddr = '0;
        endcase
    end

    always_comb
    begin
        we    = 1'b0;
        waddr = pt_reg;
        wdata = nv;
        case (cmd.wr_sel)
            WR_CLEAR:
            begin
                we    = 1'b1;
                waddr = clr_reg;
                wdata = '0;
            end
            WR_ITEM:
            begin
                we    = 1'b1;
                waddr = AW'(item.point_index);
                wdata = sat_in(item.point_value);
            end
            WR_PIN_A:
            begin
                we    = a_ok;
                waddr = AW'(pin_a_idx_reg);
                wdata = pin_a_val_reg;
            end
            WR_PIN_B:
            begin
                we    = b_ok;
                waddr = AW'(pin_b_idx_reg);
                wdata = pin_b_val_reg;
            end
            WR_POINT: we = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        if (cmd.rd_en)
            rdata_reg <= mem[raddr];
    end

    // Stencil pipeline registers
    logic signed [W-1:0]    left_reg, centre_reg, right_reg;
    logic signed [W+1:0]    lap_reg;
    logic signed [W:0]      grad_reg;
    logic signed [PW-1:0]   dprod_reg, aprod_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load_left)
            left_reg <= rdata_reg;
        if (cmd.load_centre)
            centre_reg <= rdata_reg;
        if (cmd.calc_lap)
        begin
            right_reg <= rdata_reg;
            lap_reg   <= (W+2)'(rdata_reg) + (W+2)'(left_reg) - ((W+2)'(centre_reg) <<< 1);
            grad_reg  <= (W+1)'(rdata_reg) - (W+1)'(left_reg);
        end
        if (cmd.calc_mul)
        begin
            dprod_reg <= PW'(lap_reg * $signed({1'b0, diff_reg}));
            aprod_reg <= PW'(grad_reg * adv_reg);
        end
        if (cmd.wr_sel == WR_POINT)
        begin
            left_reg   <= centre_reg;
            centre_reg <= right_reg;
        end
    end

    // Write-back: round both terms, sum, saturate, apply pins
    logic signed [PW-1:0] dround, around;
    logic signed [SW-1:0] sum;
    logic signed [W:0]    delta;
    logic [W:0]           mag;

    always_comb
    begin
        dround = (dprod_reg + RND) >>> 16;
        around = (aprod_reg + RND) >>> 16;
        sum    = SW'(centre_reg) + dround[SW-1:0] - around[SW-1:0];
        if (sum > VMAX_S) sum = VMAX_S;
        if (sum < VMIN_S) sum = VMIN_S;
        nv = sum[W-1:0];
        if (a_ok && (CW'(pt_reg) == CW'(pin_a_idx_reg))) nv = pin_a_val_reg;
        if (b_ok && (CW'(pt_reg) == CW'(pin_b_idx_reg))) nv = pin_b_val_reg;
        delta = (W+1)'(nv) - (W+1)'(centre_reg);
        mag   = delta[W] ? (W+1)'(-delta) : (W+1)'(delta);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg     <= '0;
            pt_reg      <= '0;
            worst_reg   <= '0;
            largest_reg <= '0;
            sweeps_reg  <= '0;
        end
        else
        begin
            if (cmd.wr_sel == WR_CLEAR)
                clr_reg <= clr_reg + AW'(1);
            if (cmd.load_centre)
                pt_reg <= AW'(1);
            else if (cmd.wr_sel == WR_POINT)
                pt_reg <= pt_reg + AW'(1);
            if (cmd.sweep_start)
                worst_reg <= '0;
            else if ((cmd.wr_sel == WR_POINT) && (mag > worst_reg))
                worst_reg <= mag;
            if (cmd.run_start)
                sweeps_reg <= '0;
            else if (cmd.sweep_end)
            begin
                sweeps_reg  <= sweeps_reg + 16'd1;
                largest_reg <= (TW'(worst_reg) > CMAX_T) ? 31'h7FFF_FFFF : worst_reg[30:0];
            end
        end
    end

    // Result fields
    always_ff @(posedge clk)
    begin
        case (cmd.reply)
            REP_ZERO:
            begin
                out_value  <= '0;
                out_sweeps <= '0;
                out_change <= '0;
            end
            REP_READ:
            begin
                out_value  <= sat_out(rdata_reg);
                out_sweeps <= '0;
                out_change <= '0;
            end
            REP_RUN:
            begin
                out_value  <= '0;
                out_sweeps <= sweeps_reg;
                out_change <= largest_reg;
            end
            default: ;
        endcase
    end

    assign stat.clear_done = (clr_reg == AW'(GRID_DEPTH - 1));
    assign stat.idx_ok     = CW'(item.point_index) < n;
    assign stat.unstable   = diff_reg > DIFFUSION_LIMIT;
    assign stat.last_point = (CW'(pt_reg) == (n - CW'(2)));
    assign stat.converged  = TW'(worst_reg) <= TW'(tol_reg);
    assign stat.at_limit   = sweeps_reg >= 16'(MAX_SWEEPS);

endmodule

// ===== sv/adsw_ctrl.sv =====
// Controller of the sweep block: sequences accesses, pinning and sweeps.
// Depends on adsw_pkg; commands adsw_datapath.
module adsw_ctrl
    import adsw_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  logic [1:0] func,
    input  adsw_stat_t stat,
    output adsw_cmd_t  cmd,
    output logic       busy,
    output logic       done,
    output logic [2:0] status
);

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_READ, S_RUN, S_PIN_B, S_LOAD0, S_LOAD1, S_LOAD2,
        S_RD, S_LAP, S_MUL, S_WB, S_END, S_CHECK
    } state_t;

    state_t     state_reg, state_next;
    logic       done_reg, done_next;
    logic [2:0] status_reg, status_next;

    always_comb
    begin
        cmd         = '0;
        state_next  = state_reg;
        status_next = status_reg;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.wr_sel = WR_CLEAR;
                if (stat.clear_done)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (start)
                begin
                    case (func)
                        FUNC_WRITE:
                        begin
                            cmd.reply   = REP_ZERO;
                            status_next = stat.idx_ok ? STATUS_ACCESS : STATUS_BAD;
                            if (stat.idx_ok)
                                cmd.wr_sel = WR_ITEM;
                        end
                        FUNC_READ:
                        begin
                            if (stat.idx_ok)
                            begin
                                cmd.rd_en  = 1'b1;
                                cmd.rd_sel = RD_ITEM;
                                state_next = S_READ;
                            end
                            else
                            begin
                                cmd.reply   = REP_ZERO;
                                status_next = STATUS_BAD;
                            end
                        end
                        FUNC_RUN: state_next = S_RUN;
                        default:
                        begin
                            cmd.reply   = REP_ZERO;
                            status_next = STATUS_BAD;
                        end
                    endcase
                end
            end
            S_READ:
            begin
                cmd.reply   = REP_READ;
                status_next = STATUS_ACCESS;
                state_next  = S_IDLE;
            end
            S_RUN:
            begin
                if (stat.unstable)
                begin
                    cmd.reply   = REP_ZERO;
                    status_next = STATUS_UNSTABLE;
                    state_next  = S_IDLE;
                end
                else
                begin
                    cmd.wr_sel    = WR_PIN_A;
                    cmd.run_start = 1'b1;
                    state_next    = S_PIN_B;
                end
            end
            S_PIN_B:
            begin
                cmd.wr_sel = WR_PIN_B;
                state_next = S_LOAD0;
            end
            S_LOAD0:
            begin
                cmd.rd_en       = 1'b1;
                cmd.rd_sel      = RD_ZERO;
                cmd.sweep_start = 1'b1;
                state_next      = S_LOAD1;
            end
            S_LOAD1:
            begin
                cmd.rd_en     = 1'b1;
                cmd.rd_sel    = RD_ONE;
                cmd.load_left = 1'b1;
                state_next    = S_LOAD2;
            end
            S_LOAD2:
            begin
                cmd.load_centre = 1'b1;
                state_next      = S_RD;
            end
            S_RD:
            begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = RD_NEXT;
                state_next = S_LAP;
            end
            S_LAP:
            begin
                cmd.calc_lap = 1'b1;
                state_next   = S_MUL;
            end
            S_MUL:
            begin
                cmd.calc_mul = 1'b1;
                state_next   = S_WB;
            end
            S_WB:
            begin
                cmd.wr_sel = WR_POINT;
                state_next = stat.last_point ? S_END : S_RD;
            end
            S_END:
            begin
                cmd.sweep_end = 1'b1;
                state_next    = S_CHECK;
            end
            S_CHECK:
            begin
                if (stat.converged || stat.at_limit)
                begin
                    cmd.reply   = REP_RUN;
                    status_next = stat.converged ? STATUS_CONV : STATUS_LIMIT;
                    state_next  = S_IDLE;
                end
                else
                    state_next = S_LOAD0;
            end
            default: state_next = S_IDLE;
        endcase
        done_next = (cmd.reply != REP_NONE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_CLEAR;
            done_reg   <= 1'b0;
            status_reg <= STATUS_ACCESS;
        end
        else
        begin
            state_reg  <= state_next;
            done_reg   <= done_next;
            status_reg <= status_next;
        end
    end

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign status = status_reg;

    a_write_answers_next: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && func == FUNC_WRITE) |=> done_reg)
        else $error("write transaction did not answer in the next cycle");

    a_run_not_immediate: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && func == FUNC_RUN) |=> !done_reg)
        else $error("run transaction answered without checking stability");

    a_run_result_after_check: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && (status_reg == STATUS_CONV || status_reg == STATUS_LIMIT))
        |-> $past(state_reg == S_CHECK))
        else $error("run result issued outside the sweep check");

endmodule

// ===== sv/advection_diffusion_sweep_1d.sv =====
// Top level of the 1D advection-diffusion sweep block.
// Depends on adsw_pkg, adsw_ctrl and adsw_datapath.
//
// Usage: after reset the block zeroes its grid, one point per clock, and
// holds busy high until the grid is clear. An item is taken when start is
// high and busy is low. Writes answer in the next cycle and can be issued
// back to back; a read registers the grid word, then the answer. A run
// checks stability and sets both pins; each sweep loads two points, walks the
// stencil one point at a time through read, subtract, multiply and write-back
// steps, and ends in a check that issues the result or starts another sweep.
// Each result is shown for exactly one cycle with done high; the receiver
// cannot stall it, so capture it on that cycle. Configuration writes land at
// once and should only be made while busy is low and no result is pending.
module advection_diffusion_sweep_1d
    import adsw_pkg::*;
#(
    parameter int GRID_DEPTH = 128,
    parameter int MAX_SWEEPS = 65535,
    parameter int VALUE_BITS = 32
)(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    output logic                   busy,
    input  adsw_in_t               item,
    output logic                   done,
    output adsw_out_t              result,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    adsw_cmd_t          cmd;
    adsw_stat_t         stat;
    logic [2:0]         status;
    logic signed [31:0] out_value;
    logic [15:0]        out_sweeps;
    logic [30:0]        out_change;

    // Sequence each transaction and the sweeps of a run
    adsw_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .func   (item.func),
        .stat   (stat),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done),
        .status (status)
    );

    // Hold the grid, the registers and the stencil arithmetic
    adsw_datapath #(
        .GRID_DEPTH (GRID_DEPTH),
        .MAX_SWEEPS (MAX_SWEEPS),
        .VALUE_BITS (VALUE_BITS)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (item),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .cmd        (cmd),
        .stat       (stat),
        .out_value  (out_value),
        .out_sweeps (out_sweeps),
        .out_change (out_change)
    );

    // Fields and status are registered in the same cycle as done
    assign result.read_value  = out_value;
    assign result.status      = status;
    assign result.sweep_count = out_sweeps;
    assign result.max_change  = out_change;

endmodule

// ===== sim/advection_diffusion_sweep_1d_tb.sv =====
// Self-checking testbench for advection_diffusion_sweep_1d: directed and random
// transactions checked against an in-bench predictor of the grid and its sweeps.
// Depends on adsw_pkg and the advection_diffusion_sweep_1d RTL.
module advection_diffusion_sweep_1d_tb;
    import adsw_pkg::*;

    localparam int DEPTH      = 128;
    localparam int SWEEP_MAX  = 65535;
    localparam int CYCLE_CAP  = 4000000;
    localparam longint VAL_HI = 64'sd2147483647;
    localparam longint VAL_LO = -64'sd2147483648;

    // Predictor of the sweep block plus the queue of pending results.
    class sweep_scoreboard;
        longint    grid_q[DEPTH];
        longint    diff_c;
        longint    adv_c;
        longint    tol;
        int        count_cfg;
        int        pin_a_idx, pin_b_idx;
        longint    pin_a_val, pin_b_val;
        adsw_out_t pending_q[$];
        int        errors;

        function void clear();
            foreach (grid_q[i]) grid_q[i] = 0;
            diff_c    = RST_DIFFUSION;
            adv_c     = RST_ADVECTION;
            tol       = RST_TOLERANCE;
            count_cfg = RST_COUNT;
            pin_a_idx = RST_PIN_A_IDX;
            pin_a_val = RST_PIN_A_VAL;
            pin_b_idx = RST_PIN_B_IDX;
            pin_b_val = RST_PIN_B_VAL;
            errors    = 0;
        endfunction

        function void set_reg(logic [2:0] idx, logic [31:0] data);
            case (idx)
                CFG_DIFFUSION: diff_c    = data[15:0];
                CFG_ADVECTION: adv_c     = $signed(data[16:0]);
                CFG_TOLERANCE: tol       = data[30:0];
                CFG_COUNT:     count_cfg = data[7:0];
                CFG_PIN_A_IDX: pin_a_idx = data[6:0];
                CFG_PIN_A_VAL: pin_a_val = $signed(data);
                CFG_PIN_B_IDX: pin_b_idx = data[6:0];
                CFG_PIN_B_VAL: pin_b_val = $signed(data);
                default: ;
            endcase
        endfunction

        function int active_points();
            if (count_cfg < 3) return 3;
            if (count_cfg > DEPTH) return DEPTH;
            return count_cfg;
        endfunction

        // Exact product scaled by 2^-16, rounded to nearest, ties upward.
        function longint scale_q16(longint x, longint c);
            longint lo, hi;
            lo = x & 64'hFFFF;
            hi = (x - lo) / 65536;
            return hi * c + ((lo * c + 32768) >>> 16);
        endfunction

        function longint clamp_val(longint x);
            if (x > VAL_HI) return VAL_HI;
            if (x < VAL_LO) return VAL_LO;
            return x;
        endfunction

        // Advance the model by one transaction; return the sweeps it takes.
        function int note_item(adsw_in_t it);
            adsw_out_t exp_r;
            int        n, sweeps;
            bit        a_ok, b_ok, fin;
            longint    worst, left_v, mid_v, right_v, nv, dlt;
            exp_r  = '0;
            exp_r.status = STATUS_BAD;
            n      = active_points();
            sweeps = 0;
            if (it.func == FUNC_WRITE || it.func == FUNC_READ) begin
                if (it.point_index < n) begin
                    exp_r.status = STATUS_ACCESS;
                    if (it.func == FUNC_WRITE)
                        grid_q[it.point_index] = it.point_value;
                    else
                        exp_r.read_value = grid_q[it.point_index];
                end
            end else if (it.func == FUNC_RUN) begin
                if (diff_c > DIFFUSION_LIMIT) begin
                    exp_r.status = STATUS_UNSTABLE;
                end else begin
                    a_ok = pin_a_idx < n;
                    b_ok = pin_b_idx < n;
                    if (a_ok) grid_q[pin_a_idx] = pin_a_val;
                    if (b_ok) grid_q[pin_b_idx] = pin_b_val;
                    fin = 0;
                    while (!fin) begin
                        worst  = 0;
                        left_v = grid_q[0];
                        for (int i = 1; i + 1 < n; i++) begin
                            right_v = grid_q[i + 1];
                            mid_v   = grid_q[i];
                            nv = mid_v + scale_q16(right_v + left_v - 2 * mid_v, diff_c)
                                 - scale_q16(right_v - left_v, adv_c);
                            nv = clamp_val(nv);
                            if (a_ok && i == pin_a_idx) nv = pin_a_val;
                            if (b_ok && i == pin_b_idx) nv = pin_b_val;
                            dlt = nv - mid_v;
                            if (dlt < 0) dlt = -dlt;
                            if (dlt > worst) worst = dlt;
                            grid_q[i] = nv;
                            left_v = mid_v;
                        end
                        sweeps++;
                        exp_r.max_change = (worst > VAL_HI) ? VAL_HI : worst;
                        if (worst <= tol) begin
                            exp_r.status = STATUS_CONV;
                            fin = 1;
                        end else if (sweeps >= SWEEP_MAX) begin
                            exp_r.status = STATUS_LIMIT;
                            fin = 1;
                        end
                    end
                    exp_r.sweep_count = sweeps;
                end
            end
            pending_q.push_back(exp_r);
            return sweeps;
        endfunction

        task report(string what, longint got, longint want);
            $display("mismatch on %s: got %0d, expected %0d", what, got, want);
            errors++;
        endtask

        task check_result(adsw_out_t got);
            adsw_out_t want;
            if (pending_q.size() == 0) begin
                report("unexpected result status", got.status, -1);
                return;
            end
            want = pending_q.pop_front();
            if (got.read_value !== want.read_value)
                report("read_value", got.read_value, want.read_value);
            if (got.status !== want.status)
                report("status", got.status, want.status);
            if (got.sweep_count !== want.sweep_count)
                report("sweep_count", got.sweep_count, want.sweep_count);
            if (got.max_change !== want.max_change)
                report("max_change", got.max_change, want.max_change);
        endtask
    endclass

    logic                   clk;
    logic                   rst_n;
    logic                   start;
    logic                   busy;
    adsw_in_t               item;
    logic                   done;
    adsw_out_t              result;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    sweep_scoreboard sb;
    int              cycle_cnt;
    bit              burst_mode;

    advection_diffusion_sweep_1d dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .item     (item),
        .done     (done),
        .result   (result),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Capture every result on its single strobe cycle; the block cannot be stalled.
    always @(posedge clk)
    begin
        if (rst_n && done)
            sb.check_result(result);
    end

    // Watchdog: end the run if the block stops making progress.
    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_CAP) begin
            $display("FAILURE");
            $finish;
        end
    end

    // Write one register; only called while the block is idle.
    task write_reg(logic [2:0] idx, logic [31:0] data);
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        @(negedge clk);
        cfg_we    = 1'b0;
        sb.set_reg(idx, data);
    endtask

    // Present one transaction, hold it until accepted, then idle a random gap (none in burst mode).
    task send_item(logic [1:0] func, logic [6:0] idx, logic [31:0] val);
        int gap;
        @(negedge clk);
        start            = 1'b1;
        item.func        = func;
        item.point_index = idx;
        item.point_value = val;
        @(posedge clk);
        while (busy) @(posedge clk);
        void'(sb.note_item(item));
        if (burst_mode)
            gap = 0;
        else if ($urandom_range(0, 9) < 7)
            gap = $urandom_range(0, 2);
        else
            gap = $urandom_range(5, 40);
        if (gap > 0) begin
            @(negedge clk);
            start = 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    // Drop start, wait out every pending result and let the block settle.
    task drain();
        @(negedge clk);
        start = 1'b0;
        while (sb.pending_q.size() != 0) @(posedge clk);
        while (busy) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // Pick a configuration that converges quickly so runs stay short.
    task random_config();
        int d;
        d = $urandom_range(8192, 32768);
        write_reg(CFG_DIFFUSION, d);
        write_reg(CFG_ADVECTION, $urandom_range(0, d) - d / 2);
        write_reg(CFG_TOLERANCE, $urandom_range(1 << 14, 1 << 24));
        write_reg(CFG_COUNT, ($urandom_range(0, 4) == 0) ? $urandom_range(0, 12)
                                                        : $urandom_range(3, 8));
        write_reg(CFG_PIN_A_IDX, $urandom_range(0, 9));
        write_reg(CFG_PIN_A_VAL, $urandom());
        write_reg(CFG_PIN_B_IDX, $urandom_range(0, 127));
        write_reg(CFG_PIN_B_VAL, $urandom());
    endtask

    initial
    begin
        int r, n;
        sb = new();
        sb.clear();
        cycle_cnt  = 0;
        burst_mode = 0;
        rst_n      = 1'b0;
        start      = 1'b0;
        item       = '0;
        cfg_we     = 1'b0;
        cfg_index  = '0;
        cfg_data   = '0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Accesses under reset settings: range edges, out-of-range index, unknown func.
        send_item(FUNC_READ, 0, 0);
        send_item(FUNC_READ, 100, 0);
        send_item(FUNC_READ, 101, 0);
        send_item(FUNC_WRITE, 127, 32'h7FFF_FFFF);
        send_item(2'd3, 5, 32'h1234_5678);
        send_item(FUNC_WRITE, 0, 32'h7FFF_FFFF);
        send_item(FUNC_WRITE, 1, 32'h8000_0000);
        send_item(FUNC_READ, 0, 0);
        send_item(FUNC_READ, 1, 0);
        drain();

        // Unstable diffusion is rejected without touching the grid.
        write_reg(CFG_DIFFUSION, DIFFUSION_LIMIT + 1);
        send_item(FUNC_RUN, 0, 0);
        drain();

        // Largest stable diffusion on a saturating three-point grid, pins ignored.
        write_reg(CFG_DIFFUSION, DIFFUSION_LIMIT);
        write_reg(CFG_ADVECTION, 0);
        write_reg(CFG_TOLERANCE, 31'h7FFF_FFFF);
        write_reg(CFG_COUNT, 3);
        write_reg(CFG_PIN_A_IDX, 127);
        write_reg(CFG_PIN_B_IDX, 127);
        send_item(FUNC_WRITE, 2, 32'h7FFF_FFFF);
        send_item(FUNC_RUN, 0, 0);
        send_item(FUNC_READ, 1, 0);
        drain();

        // Zero tolerance on a flat grid, advection extremes, both pins on one cell.
        write_reg(CFG_COUNT, 0);
        write_reg(CFG_DIFFUSION, 0);
        write_reg(CFG_ADVECTION, 32'h0001_0000);
        write_reg(CFG_TOLERANCE, 0);
        write_reg(CFG_PIN_A_IDX, 1);
        write_reg(CFG_PIN_A_VAL, 32'h0100_0000);
        write_reg(CFG_PIN_B_IDX, 1);
        write_reg(CFG_PIN_B_VAL, 32'hFE00_0000);
        send_item(FUNC_WRITE, 0, 0);
        send_item(FUNC_WRITE, 2, 0);
        send_item(FUNC_RUN, 0, 0);
        drain();
        write_reg(CFG_ADVECTION, 32'h0000_FFFF);
        send_item(FUNC_RUN, 0, 0);
        send_item(FUNC_READ, 1, 0);
        send_item(FUNC_READ, 3, 0);
        drain();

        // Full grid (count clamped from above), pins on end points.
        write_reg(CFG_COUNT, 255);
        write_reg(CFG_DIFFUSION, RST_DIFFUSION);
        write_reg(CFG_ADVECTION, RST_ADVECTION);
        write_reg(CFG_TOLERANCE, 1 << 28);
        write_reg(CFG_PIN_A_IDX, 0);
        write_reg(CFG_PIN_B_IDX, 127);
        send_item(FUNC_WRITE, 1, 0);
        send_item(FUNC_WRITE, 2, 0);
        send_item(FUNC_RUN, 0, 0);
        send_item(FUNC_READ, 127, 0);
        drain();

        // Random phases: mostly well-formed accesses and runs, some noise.
        for (int ph = 0; ph < 5; ph++) begin
            random_config();
            burst_mode = (ph == 2);
            n = sb.active_points();
            for (int k = 0; k < 16; k++) begin
                r = $urandom_range(0, 99);
                if (r < 40)
                    send_item(FUNC_WRITE, (r < 36) ? $urandom_range(0, n - 1)
                                                   : $urandom_range(0, 127), $urandom());
                else if (r < 70)
                    send_item(FUNC_READ, (r < 66) ? $urandom_range(0, n - 1)
                                                  : $urandom_range(0, 127), $urandom());
                else if (r < 94)
                    send_item(FUNC_RUN, $urandom_range(0, 127), $urandom());
                else
                    send_item(2'd3, $urandom_range(0, 127), $urandom());
            end
            drain();
        end

        if (sb.errors == 0 && sb.pending_q.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
